>>> design/msw_pkg.sv
// Shared types and constants for the multi-channel stopwatch core.
// No dependencies; every other file imports this package.
package msw_pkg;

    localparam int NUM_STOPWATCHES = 8;

    localparam int CHAN_W = 3;
    localparam int TIME_W = 31;
    localparam int RAW_W = 32;
    localparam int ELAPSED_W = 32;
    localparam int ADDR_W = (NUM_STOPWATCHES > 1) ? $clog2(NUM_STOPWATCHES) : 1;
    localparam int NUM_W = $clog2(NUM_STOPWATCHES + 1);
    localparam int CMP_W = CHAN_W + NUM_W;

    typedef logic [1:0] t_cmd;
    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [RAW_W-1:0] t_raw;
    typedef logic [ELAPSED_W-1:0] t_elapsed;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_cmd CMD_TICK = 2'd0;
    localparam t_cmd CMD_START = 2'd1;
    localparam t_cmd CMD_STOP = 2'd2;
    localparam t_cmd CMD_READ = 2'd3;

    localparam logic [CMP_W-1:0] NUM_CMP = CMP_W'(NUM_STOPWATCHES);

    typedef struct packed {
        logic  running;
        t_time stop_time;
        t_time start_time;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_addr  addr;
        t_entry entry;
    } t_wr_req;

    // Map a channel field onto a table address.
    function automatic t_addr chan_to_addr(t_chan chan);
        logic [ADDR_W+CHAN_W-1:0] wide;
        wide = {{ADDR_W{1'b0}}, chan};
        return wide[ADDR_W-1:0];
    endfunction

    function automatic logic chan_in_bank(t_chan chan);
        logic [CMP_W-1:0] wide;
        wide = {{NUM_W{1'b0}}, chan};
        return wide < NUM_CMP;
    endfunction

endpackage

>>> design/msw_cmd_if.sv
// Command channel of the stopwatch core: valid/ready plus command and channel.
// Depends on msw_pkg.
interface msw_cmd_if;
    import msw_pkg::*;

    logic  valid;
    logic  ready;
    t_cmd  command;
    t_chan channel;

    modport source (output valid, output command, output channel, input ready);
    modport sink (input valid, input command, input channel, output ready);
endinterface

>>> design/msw_res_if.sv
// Result channel of the stopwatch core: valid/ready plus start_ok and elapsed_us.
// Depends on msw_pkg.
interface msw_res_if;
    import msw_pkg::*;

    logic     valid;
    logic     ready;
    logic     start_ok;
    t_elapsed elapsed_us;

    modport source (output valid, output start_ok, output elapsed_us, input ready);
    modport sink (input valid, input start_ok, input elapsed_us, output ready);
endinterface

>>> design/msw_table.sv
// Channel table: one synchronous RAM of start/stop/running entries, registered read.
// Per-entry valid flops make the whole table read as zero right after reset.
// Depends on msw_pkg.
module msw_table (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  msw_pkg::t_addr   i_rd_addr,
    output msw_pkg::t_entry  o_rd_entry,
    input  msw_pkg::t_wr_req i_wr
);
    import msw_pkg::*;

    t_entry                     r_mem [NUM_STOPWATCHES];
    logic [NUM_STOPWATCHES-1:0] r_valid;
    t_entry                     r_rd_data;
    logic                       r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // An entry never written since reset reads as zero.
    assign o_rd_entry = r_rd_valid ? r_rd_data : '0;

    a_no_rd_wr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd_en && i_wr.en))
        else $error("table read and write in the same cycle");

endmodule

>>> design/multi_channel_stopwatch_core.sv
// Multi-channel stopwatch core: tick counter, command sequencer and result register.
// Depends on msw_pkg, msw_cmd_if, msw_res_if and msw_table.
//
// A bank of NUM_STOPWATCHES stopwatches sharing one 32-bit count of tick
// transfers; the time base is the count halved. A tick transfer gives no
// result. Start, stop and read each first read the channel's entry from the
// table RAM and then, in the update state, update it, write it back and load
// the result register; a new command is not taken until that update is done.
// A command whose result register is still occupied waits in its update
// state until the result is taken. The table reads as all zero straight
// after reset (per-entry valid flops), with no clearing pass. Channels at or
// beyond NUM_STOPWATCHES change nothing and return zero.
module multi_channel_stopwatch_core (
    input  logic i_clk,
    input  logic i_rst_n,
    msw_cmd_if.sink   i_cmd,
    msw_res_if.source o_res
);
    import msw_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RMW  = 1'b1;

    logic     r_state;
    t_raw     r_raw;
    t_cmd     r_cmd;
    t_addr    r_addr;
    logic     r_in_bank;
    logic     r_out_valid;
    logic     r_out_ok;
    t_elapsed r_out_elapsed;

    logic     accept;
    logic     accept_tick;
    logic     accept_cmd;
    logic     out_free;
    logic     rmw_done;
    t_entry   rd_entry;
    t_wr_req  wr_req;
    t_time    now_time;
    t_time    end_time;
    logic     n_ok;
    t_elapsed n_elapsed;

    assign i_cmd.ready  = (r_state == S_IDLE);
    assign accept       = i_cmd.valid && i_cmd.ready;
    assign accept_tick  = accept && (i_cmd.command == CMD_TICK);
    assign accept_cmd   = accept && (i_cmd.command != CMD_TICK);
    assign out_free     = !r_out_valid || o_res.ready;
    assign rmw_done     = (r_state == S_RMW) && out_free;
    assign now_time     = r_raw[RAW_W-1:1];

    msw_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept_cmd && chan_in_bank(i_cmd.channel)),
        .i_rd_addr  (chan_to_addr(i_cmd.channel)),
        .o_rd_entry (rd_entry),
        .i_wr       (wr_req)
    );

    always_comb begin
        wr_req.en    = 1'b0;
        wr_req.addr  = r_addr;
        wr_req.entry = rd_entry;
        n_ok         = 1'b0;
        n_elapsed    = '0;
        end_time     = rd_entry.stop_time;
        if (rmw_done && r_in_bank) begin
            unique case (r_cmd)
                CMD_START: begin
                    if (!rd_entry.running) begin
                        wr_req.en               = 1'b1;
                        wr_req.entry.start_time = now_time;
                        wr_req.entry.running    = 1'b1;
                        n_ok                    = 1'b1;
                    end
                end
                CMD_STOP: begin
                    // Stopping an idle channel reports the last stored interval.
                    if (rd_entry.running) begin
                        wr_req.en              = 1'b1;
                        wr_req.entry.stop_time = now_time;
                        wr_req.entry.running   = 1'b0;
                        end_time               = now_time;
                    end
                    n_elapsed = {1'b0, end_time} - {1'b0, rd_entry.start_time};
                end
                CMD_READ: begin
                    if (rd_entry.running) begin
                        end_time = now_time;
                    end
                    n_elapsed = {1'b0, end_time} - {1'b0, rd_entry.start_time};
                end
                CMD_TICK: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_raw       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept_tick) begin
                r_raw <= r_raw + t_raw'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept_cmd) begin
                        r_state <= S_RMW;
                    end
                end
                S_RMW: begin
                    if (rmw_done) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
            // Load a new result or drop the one just transferred.
            if (rmw_done) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_cmd) begin
            r_cmd     <= i_cmd.command;
            r_addr    <= chan_to_addr(i_cmd.channel);
            r_in_bank <= chan_in_bank(i_cmd.channel);
        end
        if (rmw_done) begin
            r_out_ok      <= n_ok;
            r_out_elapsed <= n_elapsed;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.start_ok   = r_out_ok;
    assign o_res.elapsed_us = r_out_elapsed;

    a_count_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept_tick |=> $stable(r_raw))
        else $error("tick count moved without a tick transfer");

    a_cmd_enters_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_cmd |=> (r_state == S_RMW))
        else $error("command transfer did not start a table update");

    a_write_in_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_req.en |-> (rmw_done && r_in_bank))
        else $error("table write outside an update cycle");

    a_start_ok_zero_elapsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.start_ok) |-> (o_res.elapsed_us == '0))
        else $error("successful start carries a nonzero elapsed time");

endmodule

>>> tb/tb_multi_channel_stopwatch_core.sv
// Self-checking testbench for multi_channel_stopwatch_core: drives tick, start, stop and
// read commands with random gaps and back-pressure, and checks every result in order.
// Depends on msw_pkg, msw_cmd_if, msw_res_if and the core.
`timescale 1ns / 1ps

module tb_multi_channel_stopwatch_core;
    import msw_pkg::*;

    localparam int CLK_HALF = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 1030;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    // Tracks the stopwatch bank and the replies still owed by the core.
    class stopwatch_tracker;
        typedef struct {
            logic     start_ok;
            t_elapsed elapsed;
        } t_reply;

        t_raw   raw_count;
        t_time  start_at [NUM_STOPWATCHES];
        t_time  stop_at  [NUM_STOPWATCHES];
        bit     running  [NUM_STOPWATCHES];
        t_reply owed_replies[$];
        int     errors;
        int     ticks_seen;
        int     replies_checked;
        int     starts_granted;
        int     starts_refused;

        function new();
            raw_count = '0;
            for (int i = 0; i < NUM_STOPWATCHES; i++) begin
                start_at[i] = '0;
                stop_at[i] = '0;
                running[i] = 1'b0;
            end
            errors = 0;
            ticks_seen = 0;
            replies_checked = 0;
            starts_granted = 0;
            starts_refused = 0;
        endfunction

        function t_time now_time();
            return raw_count[RAW_W-1:1];
        endfunction

        function t_elapsed span(t_time end_at, t_time begin_at);
            return {1'b0, end_at} - {1'b0, begin_at};
        endfunction

        // Advance the bank for one accepted command and, for all but a tick, queue its reply.
        function void note_command(t_cmd cmd, t_chan chan);
            t_reply r;
            int     idx;
            idx = int'(chan);
            r.start_ok = 1'b0;
            r.elapsed = '0;
            if (cmd == CMD_TICK) begin
                raw_count = raw_count + t_raw'(1);
                ticks_seen++;
                return;
            end
            if (idx < NUM_STOPWATCHES) begin
                case (cmd)
                    CMD_START: begin
                        if (!running[idx]) begin
                            start_at[idx] = now_time();
                            running[idx] = 1'b1;
                            r.start_ok = 1'b1;
                        end
                    end
                    CMD_STOP: begin
                        if (running[idx]) begin
                            stop_at[idx] = now_time();
                            running[idx] = 1'b0;
                        end
                        r.elapsed = span(stop_at[idx], start_at[idx]);
                    end
                    default: begin
                        r.elapsed = span(running[idx] ? now_time() : stop_at[idx],
                                         start_at[idx]);
                    end
                endcase
            end
            if (cmd == CMD_START) begin
                if (r.start_ok) starts_granted++;
                else starts_refused++;
            end
            owed_replies.push_back(r);
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= MAX_REPORTS) $display("MISMATCH: %s", what);
        endfunction

        function void check_result(logic start_ok, t_elapsed elapsed);
            t_reply want;
            if (owed_replies.size() == 0) begin
                flag($sformatf("unexpected result start_ok=%0b elapsed_us=%0d",
                               start_ok, elapsed));
                return;
            end
            want = owed_replies.pop_front();
            replies_checked++;
            if (start_ok !== want.start_ok || elapsed !== want.elapsed)
                flag($sformatf("result %0d: expected start_ok=%0b elapsed_us=%0d, got %0b %0d",
                               replies_checked, want.start_ok, want.elapsed,
                               start_ok, elapsed));
        endfunction

        function int outstanding();
            return owed_replies.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    bit   cmd_no_gaps;
    bit   res_no_gaps;

    stopwatch_tracker tracker;

    msw_cmd_if cmd_bus();
    msw_res_if res_bus();

    multi_channel_stopwatch_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_multi_channel_stopwatch_core: errors");
            $finish;
        end
    end

    // Check results before noting the command of the same edge: a result is always older.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_bus.valid && res_bus.ready)
                tracker.check_result(res_bus.start_ok, res_bus.elapsed_us);
            if (cmd_bus.valid && cmd_bus.ready)
                tracker.note_command(cmd_bus.command, cmd_bus.channel);
        end
    end

    task automatic send_command(t_cmd cmd, t_chan chan);
        int gap;
        gap = cmd_no_gaps ? 0 : $urandom_range(0, 14);
        repeat (gap) begin
            @(negedge i_clk);
            cmd_bus.valid <= 1'b0;
            cmd_bus.command <= t_cmd'($urandom);
            cmd_bus.channel <= t_chan'($urandom);
        end
        @(negedge i_clk);
        cmd_bus.valid <= 1'b1;
        cmd_bus.command <= cmd;
        cmd_bus.channel <= chan;
        do @(posedge i_clk); while (!(cmd_bus.valid && cmd_bus.ready));
    endtask

    task automatic drive_result_ready();
        int gap;
        forever begin
            gap = res_no_gaps ? 0 : $urandom_range(0, 14);
            repeat (gap) begin
                @(negedge i_clk);
                res_bus.ready <= 1'b0;
            end
            @(negedge i_clk);
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_bus.valid && res_bus.ready));
        end
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_command(CMD_TICK, t_chan'($urandom));
    endtask

    task automatic run_directed();
        send_command(CMD_READ, 3'd0);       // idle channel straight after reset
        send_command(CMD_STOP, 3'd7);       // stop on idle channel
        send_command(CMD_START, 3'd0);
        send_command(CMD_START, 3'd0);      // start on running channel
        send_ticks(5);
        send_command(CMD_READ, 3'd0);       // read while running
        send_command(CMD_START, 3'd7);
        send_ticks(3);
        send_command(CMD_STOP, 3'd0);
        send_command(CMD_READ, 3'd0);       // read after stop
        send_command(CMD_STOP, 3'd0);       // second stop keeps the old span
        send_command(CMD_START, 3'd0);      // restart
        send_ticks(2);
        send_command(CMD_READ, 3'd7);
        send_command(CMD_STOP, 3'd7);
        send_command(CMD_READ, 3'd0);
    endtask

    task automatic run_random();
        int    pick;
        int    burst;
        int    sent;
        t_cmd  cmd;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // Alternate stretches with and without idle cycles on each side.
            if ($urandom_range(0, 49) == 0) cmd_no_gaps = ~cmd_no_gaps;
            if ($urandom_range(0, 49) == 0) res_no_gaps = ~res_no_gaps;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                burst = $urandom_range(10, 60);
                send_ticks(burst);
                sent += burst;
                continue;
            end
            if (pick < 38) cmd = CMD_TICK;
            else if (pick < 58) cmd = CMD_START;
            else if (pick < 78) cmd = CMD_STOP;
            else cmd = CMD_READ;
            send_command(cmd, t_chan'($urandom));
            sent++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cycle_count = 0;
        cmd_no_gaps = 1'b0;
        res_no_gaps = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.command = CMD_TICK;
        cmd_bus.channel = '0;
        res_bus.ready = 1'b0;
        tracker = new();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        fork
            drive_result_ready();
        join_none

        run_directed();
        run_random();
        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;

        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d ticks and %0d checked replies; starts granted %0d, refused %0d",
                 tracker.ticks_seen, tracker.replies_checked,
                 tracker.starts_granted, tracker.starts_refused);
        $display("mismatches: %0d, replies left over: %0d",
                 tracker.errors, tracker.outstanding());
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("tb_multi_channel_stopwatch_core: clean");
        end else begin
            $display("tb_multi_channel_stopwatch_core: errors");
        end
        $finish;
    end

endmodule
